[rtl/core/sgig_pkg.sv]
// types, constants and offset table shared by the stitched grid index generator
`timescale 1ns / 1ps
`default_nettype none

package sgig_pkg;

  localparam int unsigned RES_W  = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned SUM_W  = 11;
  localparam int unsigned TOT_W  = 17;
  localparam int unsigned TRI_W  = 15;
  localparam int unsigned VTX_W  = 15;
  localparam int unsigned BASE_W = 16;
  localparam int unsigned QUO_W  = 8;
  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BPS;
  localparam int unsigned OFF_W  = 5;

  typedef enum logic [1:0] {
    EDGE_UPPER = 2'd0,
    EDGE_RIGHT = 2'd1,
    EDGE_LOWER = 2'd2,
    EDGE_LEFT  = 2'd3
  } edge_e;

  typedef struct packed {
    logic [3:0]       edge_pattern;
    logic [TRI_W-1:0] triangle_number;
  } in_t;

  typedef struct packed {
    logic             in_range;
    logic [VTX_W-1:0] vertex_first;
    logic [VTX_W-1:0] vertex_second;
    logic [VTX_W-1:0] vertex_third;
    logic             final_triangle;
    logic [TOT_W-1:0] pattern_index_total;
  } out_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    edge_e            edge_sel;
    logic             interior;
    logic             sparse;
    logic [CNT_W-1:0] strip_len;
    logic [TRI_W-1:0] local_num;
    logic             in_range;
    logic             final_tri;
    logic [TOT_W-1:0] idx_total;
  } seg_t;

  typedef struct packed {
    seg_t             seg;
    logic [QUO_W-1:0] row;
    logic [QUO_W-1:0] col;
  } div_t;

  // offset entry: {constant (signed 3 bits), multiple of resolution (2 bits)}
  function automatic logic [OFF_W-1:0] oe(int c0, int c1);
    return {3'(c0), 2'(c1)};
  endfunction

  // [edge][sparse][kind][vertex]
  localparam logic [OFF_W-1:0] OFFS [4][2][3][3] = '{
    '{ // upper
      '{ '{oe(0,0), oe(2,1), oe(1,0)}, '{oe(0,0), oe(1,1), oe(2,1)},
         '{oe(0,0), oe(1,1), oe(1,0)} },
      '{ '{oe(0,0), oe(1,1), oe(2,1)}, '{oe(0,0), oe(2,1), oe(2,0)},
         '{oe(2,0), oe(2,1), oe(3,1)} } },
    '{ // right
      '{ '{oe(0,0), oe(-1,0), oe(0,1)}, '{oe(0,0), oe(0,1), oe(1,1)},
         '{oe(0,0), oe(-1,0), oe(1,1)} },
      '{ '{oe(0,0), oe(-1,0), oe(0,1)}, '{oe(0,0), oe(0,1), oe(2,2)},
         '{oe(0,1), oe(1,2), oe(2,2)} } },
    '{ // lower
      '{ '{oe(1,0), oe(0,0), oe(1,1)}, '{oe(1,0), oe(1,1), oe(2,1)},
         '{oe(0,0), oe(1,1), oe(2,1)} },
      '{ '{oe(1,0), oe(0,0), oe(1,1)}, '{oe(1,0), oe(1,1), oe(3,1)},
         '{oe(2,0), oe(1,0), oe(3,1)} } },
    '{ // left
      '{ '{oe(0,0), oe(2,1), oe(1,0)}, '{oe(0,0), oe(1,1), oe(2,1)},
         '{oe(0,0), oe(1,1), oe(1,0)} },
      '{ '{oe(1,0), oe(0,0), oe(2,1)}, '{oe(0,0), oe(2,2), oe(2,1)},
         '{oe(2,1), oe(2,2), oe(3,2)} } }
  };

endpackage

`default_nettype wire

[rtl/core/sgig_seg.sv]
// strip counts, pattern totals and segment lookup, two pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module sgig_seg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sgig_pkg::in_t                  in_data_i,
  input  logic [sgig_pkg::RES_W-1:0]     res_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sgig_pkg::seg_t                 out_data_o
);

  logic                           a_valid_q;
  logic [3:0]                     a_pat_q;
  logic [sgig_pkg::TRI_W-1:0]     a_tri_q;
  logic [sgig_pkg::RES_W-1:0]     a_res_q;
  logic [sgig_pkg::CNT_W-1:0]     a_ns_q, a_nd_q;
  logic [sgig_pkg::TOT_W-1:0]     a_inner_q;
  logic [sgig_pkg::SUM_W-1:0]     a_p1_q, a_p2_q, a_p3_q, a_p4_q;
  logic                           b_valid_q;
  sgig_pkg::seg_t                 b_data_q;
  logic                           a_ready, b_ready;

  logic [sgig_pkg::RES_W-1:0]     rm2;
  logic [15:0]                    sq;
  logic [sgig_pkg::CNT_W-1:0]     ns, nd, n0, n1, n2, n3;
  logic [sgig_pkg::SUM_W-1:0]     p1, p2, p3, p4;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    rm2 = res_i - 8'd2;
    sq  = {8'd0, rm2} * {8'd0, rm2};
    ns  = {1'b0, res_i} + {2'b0, res_i[7:1]} - 9'd2;
    nd  = {res_i, 1'b0} - 9'd2;
    n0  = in_data_i.edge_pattern[0] ? ns : nd;
    n1  = in_data_i.edge_pattern[1] ? ns : nd;
    n2  = in_data_i.edge_pattern[2] ? ns : nd;
    n3  = in_data_i.edge_pattern[3] ? ns : nd;
    p1  = {2'b0, n0};
    p2  = p1 + {2'b0, n1};
    p3  = p2 + {2'b0, n2};
    p4  = p3 + {2'b0, n3};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_pat_q   <= in_data_i.edge_pattern;
      a_tri_q   <= in_data_i.triangle_number;
      a_res_q   <= res_i;
      a_ns_q    <= ns;
      a_nd_q    <= nd;
      a_inner_q <= {sq, 1'b0};
      a_p1_q    <= p1;
      a_p2_q    <= p2;
      a_p3_q    <= p3;
      a_p4_q    <= p4;
    end
  end

  logic [sgig_pkg::TOT_W-1:0] total, t_ext;
  logic [sgig_pkg::TRI_W-1:0] t_p1, t_p2, t_p3, t_p4;
  sgig_pkg::seg_t             seg_d;

  always_comb begin
    total = a_inner_q + {6'd0, a_p4_q};
    t_ext = {2'b0, a_tri_q};
    t_p1  = {4'd0, a_p1_q};
    t_p2  = {4'd0, a_p2_q};
    t_p3  = {4'd0, a_p3_q};
    t_p4  = {4'd0, a_p4_q};
    seg_d.res       = a_res_q;
    seg_d.interior  = 1'b0;
    seg_d.in_range  = t_ext < total;
    seg_d.final_tri = t_ext == (total - 17'd1);
    seg_d.idx_total = {total[15:0], 1'b0} + total;
    if (a_tri_q < t_p1) begin
      seg_d.edge_sel  = sgig_pkg::EDGE_UPPER;
      seg_d.local_num = a_tri_q;
    end else if (a_tri_q < t_p2) begin
      seg_d.edge_sel  = sgig_pkg::EDGE_RIGHT;
      seg_d.local_num = a_tri_q - t_p1;
    end else if (a_tri_q < t_p3) begin
      seg_d.edge_sel  = sgig_pkg::EDGE_LOWER;
      seg_d.local_num = a_tri_q - t_p2;
    end else if (a_tri_q < t_p4) begin
      seg_d.edge_sel  = sgig_pkg::EDGE_LEFT;
      seg_d.local_num = a_tri_q - t_p3;
    end else begin
      seg_d.edge_sel  = sgig_pkg::EDGE_UPPER;
      seg_d.interior  = 1'b1;
      seg_d.local_num = a_tri_q - t_p4;
    end
    seg_d.sparse    = a_pat_q[seg_d.edge_sel] && !seg_d.interior;
    seg_d.strip_len = a_pat_q[seg_d.edge_sel] ? a_ns_q : a_nd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_data_q <= seg_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_data_q;

endmodule

`default_nettype wire

[rtl/core/sgig_div.sv]
// pipelined restoring divider splitting an interior cell number into row and column
`timescale 1ns / 1ps
`default_nettype none

module sgig_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sgig_pkg::seg_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sgig_pkg::div_t out_data_o
);

  localparam int unsigned NS  = sgig_pkg::DIV_STAGES;
  localparam int unsigned BPS = sgig_pkg::DIV_BPS;
  localparam int unsigned QW  = sgig_pkg::QUO_W;

  logic           v_q   [NS];
  sgig_pkg::seg_t s_q   [NS];
  logic [QW-1:0]  rem_q [NS];
  logic [QW-1:0]  quo_q [NS];
  logic           rdy   [NS+1];
  logic           st_v  [NS];
  sgig_pkg::seg_t st_s  [NS];
  logic [QW-1:0]  st_rem[NS];
  logic [QW-1:0]  st_quo[NS];

  assign rdy[NS]    = out_ready_i;
  assign in_ready_o = rdy[0];

  assign st_v[0]   = in_valid_i;
  assign st_s[0]   = in_data_i;
  assign st_rem[0] = {2'b0, in_data_i.local_num[14:9]};
  assign st_quo[0] = '0;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [QW-1:0] cell_lo, dvs, rem, quo;
    logic [QW:0]   trial;

    assign rdy[g] = !v_q[g] || rdy[g+1];

    if (g > 0) begin : g_link
      assign st_v[g]   = v_q[g-1];
      assign st_s[g]   = s_q[g-1];
      assign st_rem[g] = rem_q[g-1];
      assign st_quo[g] = quo_q[g-1];
    end

    always_comb begin
      cell_lo = st_s[g].local_num[QW:1];
      dvs     = st_s[g].res - 8'd2;
      rem     = st_rem[g];
      quo     = st_quo[g];
      trial   = '0;
      for (int j = 0; j < BPS; j++) begin
        trial = {rem, cell_lo[QW-1-(g*BPS)-j]};
        if (trial >= {1'b0, dvs}) begin
          rem = QW'(trial - {1'b0, dvs});
          quo = {quo[QW-2:0], 1'b1};
        end else begin
          rem = trial[QW-1:0];
          quo = {quo[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_q[g] <= st_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && st_v[g]) begin
        s_q[g]   <= st_s[g];
        rem_q[g] <= rem;
        quo_q[g] <= quo;
      end
    end
  end

  assign out_valid_o    = v_q[NS-1];
  assign out_data_o.seg = s_q[NS-1];
  assign out_data_o.row = quo_q[NS-1];
  assign out_data_o.col = rem_q[NS-1];

endmodule

`default_nettype wire

[rtl/core/sgig_vtx.sv]
// triangle position decode, base vertex multiply and offset add, three stages
`timescale 1ns / 1ps
`default_nettype none

module sgig_vtx (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sgig_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sgig_pkg::out_t out_data_o
);

  typedef struct packed {
    logic [7:0]                  m;
    logic [7:0]                  col;
    logic [7:0]                  w;
    logic [7:0]                  res;
    logic [2:0][sgig_pkg::OFF_W-1:0] off;
    logic                        in_range;
    logic                        final_tri;
    logic [sgig_pkg::TOT_W-1:0]  idx_total;
  } v1_t;

  typedef struct packed {
    logic [sgig_pkg::BASE_W-1:0] base;
    logic [7:0]                  res;
    logic [2:0][sgig_pkg::OFF_W-1:0] off;
    logic                        in_range;
    logic                        final_tri;
    logic [sgig_pkg::TOT_W-1:0]  idx_total;
  } v2_t;

  logic           v1_valid_q, v2_valid_q, v3_valid_q;
  v1_t            v1_q, v1_d;
  v2_t            v2_q, v2_d;
  sgig_pkg::out_t v3_q, v3_d;
  logic           v1_rdy, v2_rdy, v3_rdy;

  assign v3_rdy     = !v3_valid_q || out_ready_i;
  assign v2_rdy     = !v2_valid_q || v3_rdy;
  assign v1_rdy     = !v1_valid_q || v2_rdy;
  assign in_ready_o = v1_rdy;

  sgig_pkg::seg_t seg;
  logic [9:0]     s;
  logic [17:0]    prod3;
  logic [8:0]     q3;
  logic [9:0]     kind_w;
  logic [9:0]     half;
  logic [7:0]     pos;
  logic [1:0]     kind, tbl_e;
  logic           tbl_sp;

  always_comb begin
    seg    = in_data_i.seg;
    s      = {1'b0, seg.local_num[8:0]} + 10'd1;
    prod3  = {8'd0, s} * 18'd171;
    q3     = prod3[17:9];
    kind_w = s - {q3, 1'b0} - {1'b0, q3};
    half   = ({1'b0, seg.local_num[8:0]} + 10'd1) >> 1;
    if (seg.sparse) begin
      pos  = {q3[6:0], 1'b0};
      kind = kind_w[1:0];
    end else if (seg.local_num == {6'd0, seg.strip_len - 9'd1}) begin
      pos  = seg.res - 8'd1;
      kind = 2'd2;
    end else if (seg.local_num == '0 && seg.edge_sel == sgig_pkg::EDGE_UPPER) begin
      pos  = 8'd0;
      kind = 2'd0;
    end else begin
      pos  = half[7:0];
      kind = seg.local_num[0] ? 2'd0 : 2'd1;
    end
    unique case (seg.edge_sel)
      sgig_pkg::EDGE_UPPER: begin
        v1_d.m   = 8'd0;
        v1_d.col = pos;
      end
      sgig_pkg::EDGE_RIGHT: begin
        v1_d.m   = pos;
        v1_d.col = seg.res;
      end
      sgig_pkg::EDGE_LOWER: begin
        v1_d.m   = seg.res - 8'd1;
        v1_d.col = pos;
      end
      default: begin
        v1_d.m   = pos;
        v1_d.col = 8'd0;
      end
    endcase
    tbl_e  = seg.edge_sel;
    tbl_sp = seg.sparse;
    if (seg.interior) begin
      v1_d.m   = in_data_i.row + 8'd1;
      v1_d.col = in_data_i.col + 8'd1;
      tbl_e    = sgig_pkg::EDGE_UPPER;
      tbl_sp   = 1'b0;
      kind     = {1'b0, seg.local_num[0]};
    end
    v1_d.w         = seg.res + 8'd1;
    v1_d.res       = seg.res;
    for (int k = 0; k < 3; k++) begin
      v1_d.off[k] = sgig_pkg::OFFS[tbl_e][tbl_sp][kind][k];
    end
    v1_d.in_range  = seg.in_range;
    v1_d.final_tri = seg.final_tri;
    v1_d.idx_total = seg.idx_total;
  end

  always_comb begin
    v2_d.base      = {8'd0, v1_q.m} * {8'd0, v1_q.w} + {8'd0, v1_q.col};
    v2_d.res       = v1_q.res;
    v2_d.off       = v1_q.off;
    v2_d.in_range  = v1_q.in_range;
    v2_d.final_tri = v1_q.final_tri;
    v2_d.idx_total = v1_q.idx_total;
  end

  logic [17:0] vsum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsum[k] = {2'b0, v2_q.base}
              + {{15{v2_q.off[k][4]}}, v2_q.off[k][4:2]}
              + {16'd0, v2_q.off[k][1:0]} * {10'd0, v2_q.res};
    end
    v3_d.in_range            = v2_q.in_range;
    v3_d.vertex_first        = v2_q.in_range ? vsum[0][14:0] : '0;
    v3_d.vertex_second       = v2_q.in_range ? vsum[1][14:0] : '0;
    v3_d.vertex_third        = v2_q.in_range ? vsum[2][14:0] : '0;
    v3_d.final_triangle      = v2_q.in_range && v2_q.final_tri;
    v3_d.pattern_index_total = v2_q.idx_total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_valid_q <= 1'b0;
      v2_valid_q <= 1'b0;
      v3_valid_q <= 1'b0;
    end else begin
      if (v1_rdy) begin
        v1_valid_q <= in_valid_i;
      end
      if (v2_rdy) begin
        v2_valid_q <= v1_valid_q;
      end
      if (v3_rdy) begin
        v3_valid_q <= v2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_rdy && in_valid_i) begin
      v1_q <= v1_d;
    end
    if (v2_rdy && v1_valid_q) begin
      v2_q <= v2_d;
    end
    if (v3_rdy && v2_valid_q) begin
      v3_q <= v3_d;
    end
  end

  assign out_valid_o = v3_valid_q;
  assign out_data_o  = v3_q;

  ap_final_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.final_triangle |-> out_data_o.in_range)
    else $error("final triangle flagged outside the pattern");

  ap_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      out_data_o.vertex_first == '0 && out_data_o.vertex_second == '0 &&
      out_data_o.vertex_third == '0)
    else $error("vertices not cleared for out of range triangle");

  ap_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_valid_q && v2_rdy |=> v2_valid_q)
    else $error("item lost between decode and multiply stages");

endmodule

`default_nettype wire

[rtl/core/stitched_grid_index_generator.sv]
// top level of the stitched grid index generator
`timescale 1ns / 1ps
`default_nettype none

// Returns the three row-major vertex numbers of one triangle of a terrain
// patch index list, for a 4-bit edge pattern (1 upper, 2 right, 4 lower,
// 8 left sparse) and a triangle number, with the in-range and last flags and
// the pattern's index count. One triangle is accepted every clock unless
// stalled. Two stages do count and segment lookup, four the row/column
// divider (two quotient bits per stage), three position decode, base
// multiply and offset add. Write the resolution register through the cfg
// channel only while no transfer is in flight; the block does not check.

module stitched_grid_index_generator #(
  parameter int unsigned MAX_RESOLUTION = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sgig_pkg::RES_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sgig_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sgig_pkg::out_t             out_data_o
);

  localparam logic [8:0] MAX_R = 9'(MAX_RESOLUTION);

  logic [sgig_pkg::RES_W-1:0] res_q, res_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= 8'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      res_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    res_eff = {res_q[7:1], 1'b0};
    if (res_eff < 8'd4) begin
      res_eff = 8'd4;
    end
    if ({1'b0, res_eff} > MAX_R) begin
      res_eff = {MAX_R[7:1], 1'b0};
    end
  end

  logic           seg_valid, seg_ready, div_valid, div_ready;
  sgig_pkg::seg_t seg_data;
  sgig_pkg::div_t div_data;

  sgig_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_i       (res_eff),
    .out_valid_o (seg_valid),
    .out_ready_i (seg_ready),
    .out_data_o  (seg_data)
  );

  sgig_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_valid),
    .in_ready_o  (seg_ready),
    .in_data_i   (seg_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  sgig_vtx u_vtx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_data_i   (div_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
